FILE: rtl/lic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_pkg
// Shared widths, status codes and word types of the line intersection block.
// ----------------------------------------------------------------------------
package lic_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DEN_W     = PROD_W + 1;
    localparam int NUM_W     = PROD_W + 2;
    localparam int Q_STEPS   = DATA_W + 1;
    localparam int CMP_W     = DEN_W + Q_STEPS;

    localparam logic [1:0] ST_LINE1    = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_LINE2    = 2'd2;
    localparam logic [1:0] ST_BOTH     = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] dir1_x;
        logic signed [DATA_W-1:0] dir1_y;
        logic signed [DATA_W-1:0] base1_x;
        logic signed [DATA_W-1:0] base1_y;
        logic signed [DATA_W-1:0] dir2_x;
        logic signed [DATA_W-1:0] dir2_y;
        logic signed [DATA_W-1:0] base2_x;
        logic signed [DATA_W-1:0] base2_y;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] param_t;
        logic signed [DATA_W-1:0] param_s;
        logic signed [DATA_W-1:0] cross_x;
        logic signed [DATA_W-1:0] cross_y;
    } t_out_word;

    typedef struct packed {
        logic [NUM_W-1:0] num_t;
        logic [NUM_W-1:0] num_s;
        logic [DEN_W-1:0] den;
        logic             neg_t;
        logic             neg_s;
        logic             parallel;
        t_in_word         line;
    } t_div_word;

    typedef struct packed {
        logic [Q_STEPS-1:0] q_t;
        logic [Q_STEPS-1:0] q_s;
        logic               neg_t;
        logic               neg_s;
        logic               parallel;
        t_in_word           line;
    } t_quo_word;

endpackage

FILE: rtl/lic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_front
// Four stages: base offsets, cross products, determinant and numerators,
// then magnitudes and quotient signs.
// ----------------------------------------------------------------------------
module lic_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  lic_pkg::t_in_word i_data,
    output logic              o_valid,
    output lic_pkg::t_div_word o_data
);
    import lic_pkg::*;

    logic [3:0] r_vld;

    t_in_word                r0_in;
    logic signed [DATA_W:0]  r0_bx, r0_by;

    t_in_word                r1_in;
    logic signed [PROD_W-1:0] r1_deta, r1_detb;
    logic signed [PROD_W:0]   r1_nta, r1_ntb, r1_nsa, r1_nsb;

    t_in_word                r2_in;
    logic signed [DEN_W-1:0] r2_det;
    logic signed [NUM_W-1:0] r2_nt, r2_ns;

    t_div_word               r3_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_in <= i_data;
            r0_bx <= (DATA_W+1)'(i_data.base2_x) - (DATA_W+1)'(i_data.base1_x);
            r0_by <= (DATA_W+1)'(i_data.base2_y) - (DATA_W+1)'(i_data.base1_y);

            r1_in   <= r0_in;
            r1_deta <= $signed(r0_in.dir2_x) * $signed(r0_in.dir1_y);
            r1_detb <= $signed(r0_in.dir1_x) * $signed(r0_in.dir2_y);
            r1_nta  <= $signed(r0_in.dir2_x) * r0_by;
            r1_ntb  <= $signed(r0_in.dir2_y) * r0_bx;
            r1_nsa  <= $signed(r0_in.dir1_x) * r0_by;
            r1_nsb  <= $signed(r0_in.dir1_y) * r0_bx;

            r2_in  <= r1_in;
            r2_det <= DEN_W'(r1_deta) - DEN_W'(r1_detb);
            r2_nt  <= NUM_W'(r1_nta) - NUM_W'(r1_ntb);
            r2_ns  <= NUM_W'(r1_nsa) - NUM_W'(r1_nsb);

            r3_out.line     <= r2_in;
            r3_out.num_t    <= r2_nt[NUM_W-1] ? NUM_W'(0) - r2_nt : r2_nt;
            r3_out.num_s    <= r2_ns[NUM_W-1] ? NUM_W'(0) - r2_ns : r2_ns;
            r3_out.den      <= r2_det[DEN_W-1] ? DEN_W'(0) - r2_det : r2_det;
            r3_out.neg_t    <= r2_nt[NUM_W-1] ^ r2_det[DEN_W-1];
            r3_out.neg_s    <= r2_ns[NUM_W-1] ^ r2_det[DEN_W-1];
            r3_out.parallel <= (r2_det == '0);
        end
    end

    assign o_valid = r_vld[3];
    assign o_data  = r3_out;

endmodule

FILE: rtl/lic_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_div
// Pipelined restoring divider, one quotient bit per stage, for both
// numerators over the shared determinant. The top quotient bit flags overflow.
// ----------------------------------------------------------------------------
module lic_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lic_pkg::t_div_word i_data,
    output logic               o_valid,
    output lic_pkg::t_quo_word o_data
);
    import lic_pkg::*;

    logic                r_vld   [0:Q_STEPS];
    logic [CMP_W-1:0]    r_rem_t [0:Q_STEPS];
    logic [CMP_W-1:0]    r_rem_s [0:Q_STEPS];
    logic [Q_STEPS-1:0]  r_q_t   [0:Q_STEPS];
    logic [Q_STEPS-1:0]  r_q_s   [0:Q_STEPS];
    logic [DEN_W-1:0]    r_den   [0:Q_STEPS];
    logic                r_neg_t [0:Q_STEPS];
    logic                r_neg_s [0:Q_STEPS];
    logic                r_par   [0:Q_STEPS];
    t_in_word            r_line  [0:Q_STEPS];

    logic [CMP_W-1:0]    dsh     [1:Q_STEPS];
    logic                ge_t    [1:Q_STEPS];
    logic                ge_s    [1:Q_STEPS];
    logic [CMP_W-1:0]    n_rem_t [1:Q_STEPS];
    logic [CMP_W-1:0]    n_rem_s [1:Q_STEPS];
    logic [Q_STEPS-1:0]  n_q_t   [1:Q_STEPS];
    logic [Q_STEPS-1:0]  n_q_s   [1:Q_STEPS];

    // Stage k decides quotient bit Q_STEPS-k.
    always_comb begin
        for (int k = 1; k <= Q_STEPS; k++) begin
            dsh[k]     = CMP_W'(r_den[k-1]) << (Q_STEPS - k);
            ge_t[k]    = r_rem_t[k-1] >= dsh[k];
            ge_s[k]    = r_rem_s[k-1] >= dsh[k];
            n_rem_t[k] = ge_t[k] ? r_rem_t[k-1] - dsh[k] : r_rem_t[k-1];
            n_rem_s[k] = ge_s[k] ? r_rem_s[k-1] - dsh[k] : r_rem_s[k-1];
            n_q_t[k]   = r_q_t[k-1];
            n_q_s[k]   = r_q_s[k-1];
            n_q_t[k][Q_STEPS-k] = ge_t[k];
            n_q_s[k][Q_STEPS-k] = ge_s[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= Q_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_t[0] <= CMP_W'(i_data.num_t) << FRAC_BITS;
            r_rem_s[0] <= CMP_W'(i_data.num_s) << FRAC_BITS;
            r_q_t[0]   <= '0;
            r_q_s[0]   <= '0;
            r_den[0]   <= i_data.den;
            r_neg_t[0] <= i_data.neg_t;
            r_neg_s[0] <= i_data.neg_s;
            r_par[0]   <= i_data.parallel;
            r_line[0]  <= i_data.line;
            for (int k = 1; k <= Q_STEPS; k++) begin
                r_rem_t[k] <= n_rem_t[k];
                r_rem_s[k] <= n_rem_s[k];
                r_q_t[k]   <= n_q_t[k];
                r_q_s[k]   <= n_q_s[k];
                r_den[k]   <= r_den[k-1];
                r_neg_t[k] <= r_neg_t[k-1];
                r_neg_s[k] <= r_neg_s[k-1];
                r_par[k]   <= r_par[k-1];
                r_line[k]  <= r_line[k-1];
            end
        end
    end

    assign o_valid         = r_vld[Q_STEPS];
    assign o_data.q_t      = r_q_t[Q_STEPS];
    assign o_data.q_s      = r_q_s[Q_STEPS];
    assign o_data.neg_t    = r_neg_t[Q_STEPS];
    assign o_data.neg_s    = r_neg_s[Q_STEPS];
    assign o_data.parallel = r_par[Q_STEPS];
    assign o_data.line     = r_line[Q_STEPS];

endmodule

FILE: rtl/lic_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_point
// Saturates the parameters, picks the line, and forms the intersection
// point over three stages; the last stage is the output register.
// ----------------------------------------------------------------------------
module lic_point (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lic_pkg::t_quo_word i_data,
    output logic               o_valid,
    output lic_pkg::t_out_word o_data
);
    import lic_pkg::*;

    function automatic logic [DATA_W:0] fix_param(input logic [Q_STEPS-1:0] q,
                                                 input logic neg);
        logic [Q_STEPS-1:0] limit;
        logic [DATA_W-1:0]  mag;
        logic               sat;
        limit = neg ? (Q_STEPS'(1) << (DATA_W-1))
                    : (Q_STEPS'(1) << (DATA_W-1)) - Q_STEPS'(1);
        sat   = q > limit;
        mag   = sat ? limit[DATA_W-1:0] : q[DATA_W-1:0];
        return {sat, neg ? DATA_W'(0) - mag : mag};
    endfunction

    function automatic logic [DATA_W-1:0] sat_w(input logic [PROD_W:0] v);
        logic [DATA_W-1:0] res;
        if (!v[PROD_W] && (|v[PROD_W-1:DATA_W-1])) begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v[PROD_W] && !(&v[PROD_W-1:DATA_W-1])) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    logic [2:0] r_vld;

    logic [DATA_W:0] fp_t, fp_s;
    logic [1:0]      n1_status;

    logic [1:0]               r1_status, r2_status;
    logic [DATA_W-1:0]        r1_t, r1_s, r2_t, r2_s;
    logic signed [DATA_W-1:0] r1_dx, r1_dy, r1_k;
    logic [DATA_W-1:0]        r1_bx, r1_by, r2_bx, r2_by;
    logic signed [PROD_W-1:0] r2_prod_x, r2_prod_y;
    logic [PROD_W:0]          sum_x, sum_y;
    t_out_word                r3_out;

    always_comb begin
        fp_t = fix_param(i_data.q_t, i_data.neg_t);
        fp_s = fix_param(i_data.q_s, i_data.neg_s);
        if (i_data.parallel) begin
            n1_status = ST_PARALLEL;
        end else if (fp_t[DATA_W]) begin
            n1_status = fp_s[DATA_W] ? ST_BOTH : ST_LINE2;
        end else begin
            n1_status = ST_LINE1;
        end
    end

    // Floor of the product by the fraction scale, plus the base point.
    assign sum_x = {r2_prod_x[PROD_W-1], r2_prod_x >>> FRAC_BITS}
                 + {{(PROD_W+1-DATA_W){r2_bx[DATA_W-1]}}, r2_bx};
    assign sum_y = {r2_prod_y[PROD_W-1], r2_prod_y >>> FRAC_BITS}
                 + {{(PROD_W+1-DATA_W){r2_by[DATA_W-1]}}, r2_by};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_status <= n1_status;
            r1_t      <= i_data.parallel ? '0 : fp_t[DATA_W-1:0];
            r1_s      <= i_data.parallel ? '0 : fp_s[DATA_W-1:0];
            if (fp_t[DATA_W]) begin
                r1_dx <= i_data.line.dir2_x;
                r1_dy <= i_data.line.dir2_y;
                r1_bx <= i_data.line.base2_x;
                r1_by <= i_data.line.base2_y;
                r1_k  <= $signed(fp_s[DATA_W-1:0]);
            end else begin
                r1_dx <= i_data.line.dir1_x;
                r1_dy <= i_data.line.dir1_y;
                r1_bx <= i_data.line.base1_x;
                r1_by <= i_data.line.base1_y;
                r1_k  <= $signed(fp_t[DATA_W-1:0]);
            end

            r2_status <= r1_status;
            r2_t      <= r1_t;
            r2_s      <= r1_s;
            r2_bx     <= r1_bx;
            r2_by     <= r1_by;
            r2_prod_x <= r1_dx * r1_k;
            r2_prod_y <= r1_dy * r1_k;

            r3_out.status  <= r2_status;
            r3_out.param_t <= r2_t;
            r3_out.param_s <= r2_s;
            r3_out.cross_x <= (r2_status == ST_PARALLEL) ? '0 : sat_w(sum_x);
            r3_out.cross_y <= (r2_status == ST_PARALLEL) ? '0 : sat_w(sum_y);
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r3_out;

endmodule

FILE: rtl/line_intersection_cramer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_intersection_cramer
// Intersection of two parametric lines in signed fixed point by Cramer's rule.
// ----------------------------------------------------------------------------
// The block takes one word per cycle when not stalled and returns one
// result word for each, in order: four front stages form the base offsets,
// the cross products, the determinant with both numerators and their
// magnitudes; 34 divider stages follow, a load stage and then 33 that each
// resolve one quotient bit for t and s at once, the first of those flagging
// overflow; three back stages saturate the parameters, pick the line and
// form the point, the last being the output register. The whole pipeline
// halts as one while a finished result word is held by downstream stall, so
// nothing is lost or repeated; o_stall is high exactly then. A zero
// determinant returns the parallel status with all other fields zero.
module line_intersection_cramer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lic_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output lic_pkg::t_out_word o_data
);
    import lic_pkg::*;

    logic      en;
    logic      front_valid, div_valid;
    t_div_word front_data;
    t_quo_word div_data;

    // Every stage advances unless a finished word is waiting downstream.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    lic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    lic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    lic_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_data  (div_data),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

FILE: rtl/lic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_checker
// Port-level checks of the line intersection block, bound to the top level.
// ----------------------------------------------------------------------------
module lic_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input lic_pkg::t_out_word o_data
);
    import lic_pkg::*;

    localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_PARALLEL |->
            o_data.param_t == '0 && o_data.param_s == '0 &&
            o_data.cross_x == '0 && o_data.cross_y == '0)
        else $error("parallel result with nonzero fields");

    a_t_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_LINE2 || o_data.status == ST_BOTH) |->
            o_data.param_t == MAX_V || o_data.param_t == MIN_V)
        else $error("line two point without saturated t");

endmodule

bind line_intersection_cramer lic_checker u_lic_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

FILE: tb/line_intersection_cramer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_intersection_cramer_test
// Self-checking bench for the two-line intersection block.
// ----------------------------------------------------------------------------
// Line pairs are fed in bursts with random gaps while the result side stalls
// on its own pattern. Every accepted word is run through a local solver that
// computes the determinant and both numerators exactly, divides with
// truncation and saturation, and forms the point from the chosen line. The
// expected result words wait in a queue and are compared field by field
// with the words leaving the block.
// ----------------------------------------------------------------------------
module line_intersection_cramer_test;
    import lic_pkg::*;

    localparam int LATENCY     = 41;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 730;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      dut_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    t_in_word  pending_q[$];
    t_out_word solved_q[$];
    int        n_errors;
    int        n_cycles;
    bit        feed_done;
    bit        drain_wait;
    bit        in_held;
    int        gap_left;
    int        burst_left;
    int        hold_left;
    bit        hold_done;
    int        stall_mode;

    line_intersection_cramer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (dut_stall),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_word)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Quotient of (num << FRAC_BITS) / den, truncated toward zero and
    // saturated to 32 bits. The numerator fits comfortably in 130 bits.
    function automatic logic signed [31:0] sat_quotient(
        input logic signed [129:0] num, input logic signed [129:0] den,
        output bit saturated);
        logic signed [129:0] q;
        q = (num <<< FRAC_BITS) / den;
        saturated = 1'b0;
        if (q > 130'sd2147483647) begin
            saturated = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (q < -130'sd2147483648) begin
            saturated = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // Point coordinate base + floor(dir * k / 2^FRAC_BITS), saturated.
    function automatic logic signed [31:0] point_on(
        input logic signed [31:0] dir, input logic signed [31:0] base,
        input logic signed [31:0] k);
        logic signed [65:0] sum;
        sum = ((66'(dir) * 66'(k)) >>> FRAC_BITS) + 66'(base);
        if (sum > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (sum < -66'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_out_word solve_lines(input t_in_word w);
        t_out_word r;
        logic signed [129:0] off_x, off_y, det, num_t, num_s;
        bit sat_t, sat_s;
        r = '0;
        off_x = 130'(w.base2_x) - 130'(w.base1_x);
        off_y = 130'(w.base2_y) - 130'(w.base1_y);
        det   = 130'(w.dir2_x) * 130'(w.dir1_y) - 130'(w.dir1_x) * 130'(w.dir2_y);
        num_t = 130'(w.dir2_x) * off_y - 130'(w.dir2_y) * off_x;
        num_s = 130'(w.dir1_x) * off_y - 130'(w.dir1_y) * off_x;
        if (det == 0) begin
            r.status = ST_PARALLEL;
            return r;
        end
        r.param_t = sat_quotient(num_t, det, sat_t);
        r.param_s = sat_quotient(num_s, det, sat_s);
        if (sat_t) begin
            r.status  = sat_s ? ST_BOTH : ST_LINE2;
            r.cross_x = point_on(w.dir2_x, w.base2_x, r.param_s);
            r.cross_y = point_on(w.dir2_y, w.base2_y, r.param_s);
        end else begin
            r.status  = ST_LINE1;
            r.cross_x = point_on(w.dir1_x, w.base1_x, r.param_t);
            r.cross_y = point_on(w.dir1_y, w.base1_y, r.param_t);
        end
        return r;
    endfunction

    // Random coordinate: mostly modest values, sometimes full range or extremes.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            3:       return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
            default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
        endcase
    endfunction

    function automatic t_in_word rand_pair();
        t_in_word w;
        w.dir1_x  = rand_coord();
        w.dir1_y  = rand_coord();
        w.base1_x = rand_coord();
        w.base1_y = rand_coord();
        w.dir2_x  = rand_coord();
        w.dir2_y  = rand_coord();
        w.base2_x = rand_coord();
        w.base2_y = rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                // Parallel: line two's direction is a scaled copy of line one's.
                w.dir2_x = w.dir1_x * 2;
                w.dir2_y = w.dir1_y * 2;
            end
            1: begin
                // Nearly parallel, which drives t and s toward saturation.
                w.dir2_x = w.dir1_x;
                w.dir2_y = w.dir1_y + 1;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_in_word make_pair(
        input int d1x, input int d1y, input int p1x, input int p1y,
        input int d2x, input int d2y, input int p2x, input int p2y);
        t_in_word w;
        w.dir1_x = d1x; w.dir1_y = d1y; w.base1_x = p1x; w.base1_y = p1y;
        w.dir2_x = d2x; w.dir2_y = d2y; w.base2_x = p2x; w.base2_y = p2y;
        return w;
    endfunction

    // Stimulus: directed corner cases first, then random pairs.
    initial begin
        localparam int ONE = 1 << FRAC_BITS;
        localparam int MAXV = 32'h7FFFFFFF;
        localparam int MINV = 32'h80000000;
        t_in_word w;
        // Ordinary crossings: the axes at the origin, then two diagonals.
        pending_q.push_back(make_pair(ONE, 0, 0, 0, 0, ONE, 0, 0));
        pending_q.push_back(make_pair(ONE, ONE, -ONE, 0, ONE, -ONE, ONE, 0));
        // Parallel and identical lines.
        pending_q.push_back(make_pair(ONE, ONE, 0, 0, 2*ONE, 2*ONE, ONE, 0));
        pending_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_pair(ONE, 0, 5, 7, -ONE, 0, 5, 7));
        // Large determinant with t zero, so line one's base gives the point.
        pending_q.push_back(make_pair(1, 0, 0, 0, 0, MAXV, 0, MAXV));
        // Both parameters saturate.
        pending_q.push_back(make_pair(1, 0, MINV, MINV, 0, 1, MAXV, MAXV));
        // Only s saturates.
        pending_q.push_back(make_pair(ONE, 0, 0, 0, 0, 1, 0, MAXV));
        // Extreme values, alone and mixed with small ones.
        pending_q.push_back(make_pair(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV));
        pending_q.push_back(make_pair(MINV, MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV));
        pending_q.push_back(make_pair(MINV, 0, 0, 0, 0, MINV, MAXV, MINV));
        pending_q.push_back(make_pair(MAXV, 1, -1, MAXV, -1, MAXV, MINV, 0));
        pending_q.push_back(make_pair(-1, -1, -1, -1, 1, -1, 1, 1));
        // Negative products that round by flooring in the point.
        pending_q.push_back(make_pair(-3, 7, 1, -1, 5, -2, -9, 4));
        pending_q.push_back(make_pair(ONE/3, -ONE, 0, 0, -ONE, ONE/7, ONE, -ONE));
        pending_q.push_back(make_pair(-1, 0, 0, 0, 0, -1, MINV, MINV));
        for (int i = 0; i < N_RANDOM; i++) begin
            w = rand_pair();
            pending_q.push_back(w);
        end
    end

    // Driver: bursts of words with random gaps, plus one pause that lets the
    // block drain completely before the rest of the stream goes out.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            in_word    <= '0;
            gap_left   <= 0;
            burst_left <= $urandom_range(1, 20);
        end else if (!in_held) begin
            // The previous word, if any, was taken at the last rising edge.
            if (drain_wait) begin
                in_valid <= 1'b0;
                if (solved_q.size() == 0) drain_wait <= 1'b0;
            end else if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_q.size() == 0) begin
                in_valid  <= 1'b0;
                feed_done <= 1'b1;
            end else begin
                in_valid   <= 1'b1;
                in_word    <= pending_q.pop_front();
                if (pending_q.size() == 300) begin
                    drain_wait <= 1'b1;
                    burst_left <= burst_left - 1;
                end else if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern: phases of no stall, random stall and heavy stall,
    // and one long hold-off while the sender keeps offering words.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            stall_mode <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_cycles > 300) begin
            hold_done <= 1'b1;
            hold_left <= 200;
            out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        t_out_word want;
        in_held <= in_valid && dut_stall;
        if (i_rst_n) begin
            if (in_valid && !dut_stall) solved_q.push_back(solve_lines(in_word));
            if (out_valid && !out_stall) begin
                if (solved_q.size() == 0) begin
                    $error("result word with nothing expected: %h", out_word);
                    n_errors++;
                end else begin
                    want = solved_q.pop_front();
                    if (out_word.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_word.status);
                        n_errors++;
                    end
                    if (out_word.param_t !== want.param_t) begin
                        $error("param_t: expected %h, actual %h",
                               want.param_t, out_word.param_t);
                        n_errors++;
                    end
                    if (out_word.param_s !== want.param_s) begin
                        $error("param_s: expected %h, actual %h",
                               want.param_s, out_word.param_s);
                        n_errors++;
                    end
                    if (out_word.cross_x !== want.cross_x) begin
                        $error("cross_x: expected %h, actual %h",
                               want.cross_x, out_word.cross_x);
                        n_errors++;
                    end
                    if (out_word.cross_y !== want.cross_y) begin
                        $error("cross_y: expected %h, actual %h",
                               want.cross_y, out_word.cross_y);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset, then wait for the stream to drain and for the pipeline to settle.
    initial begin
        n_errors   = 0;
        n_cycles   = 0;
        feed_done  = 1'b0;
        drain_wait = 1'b0;
        hold_done  = 1'b0;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (feed_done && solved_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && solved_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
